@@ sv/sha1md_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants of the SHA-1 digest block: round constants,
// initial chaining value, working variable record, sequencer states.
// ----------------------------------------------------------------------------
package sha1md_pkg;

   localparam int WORD_W      = 32;
   localparam int BLOCK_WORDS = 16;
   localparam int HASH_WORDS  = 5;
   localparam int ROUNDS      = 80;
   localparam int ROUND_W     = 7;
   localparam int WCNT_W      = 4;
   localparam int IDX_W       = 3;
   localparam int CNT_W       = 3;
   localparam int TDATA_W     = 40;
   localparam int LEN_W       = 64;

   localparam logic [WORD_W-1:0] K0 = 32'h5A82_7999;
   localparam logic [WORD_W-1:0] K1 = 32'h6ED9_EBA1;
   localparam logic [WORD_W-1:0] K2 = 32'h8F1B_BCDC;
   localparam logic [WORD_W-1:0] K3 = 32'hCA62_C1D6;

   localparam logic [WORD_W-1:0] INIT_HASH [HASH_WORDS] = '{
      32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
   };

   // pad byte at the head of an otherwise empty word
   localparam logic [WORD_W-1:0] PAD_WORD = 32'h8000_0000;

   // round boundaries of the four function groups
   localparam logic [ROUND_W-1:0] ROUND_G1   = 7'd20;
   localparam logic [ROUND_W-1:0] ROUND_G2   = 7'd40;
   localparam logic [ROUND_W-1:0] ROUND_G3   = 7'd60;
   localparam logic [ROUND_W-1:0] ROUND_LAST = 7'(ROUNDS - 1);

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      logic [WORD_W-1:0] d;
      logic [WORD_W-1:0] e;
   } vars_type;

   typedef struct packed {
      logic shift;
      logic expand;
   } sched_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_PAD    = 4'b0010,
      ST_ROUND  = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

endpackage

@@ sv/sha1md_sched.sv @@
// ----------------------------------------------------------------------------
// sha1md_sched
// Sixteen-word block buffer and message schedule. Words are shifted in at
// the top while a block is collected; during compression the window slides
// one place per round and the top slot takes the next expanded word.
// ----------------------------------------------------------------------------
module sha1md_sched (
   input  logic                              clock,
   input  sha1md_pkg::sched_ctrl_type        ctrl,
   input  logic [sha1md_pkg::WORD_W-1:0]     push_word,
   output logic [sha1md_pkg::WORD_W-1:0]     wt
);

   logic [sha1md_pkg::WORD_W-1:0] win_ff [sha1md_pkg::BLOCK_WORDS];
   logic [sha1md_pkg::WORD_W-1:0] win_in [sha1md_pkg::BLOCK_WORDS];
   logic [sha1md_pkg::WORD_W-1:0] mix;
   logic [sha1md_pkg::WORD_W-1:0] expanded;

   assign mix      = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
   assign expanded = {mix[sha1md_pkg::WORD_W-2:0], mix[sha1md_pkg::WORD_W-1]};
   assign wt       = win_ff[0];

   always_comb begin
      win_in = win_ff;
      if (ctrl.shift) begin
         for (int i = 0; i < sha1md_pkg::BLOCK_WORDS - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[sha1md_pkg::BLOCK_WORDS-1] = ctrl.expand ? expanded : push_word;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

@@ sv/sha1md_round.sv @@
// ----------------------------------------------------------------------------
// sha1md_round
// One SHA-1 round: selects function and constant by round number and
// produces the next set of working variables.
// ----------------------------------------------------------------------------
module sha1md_round (
   input  sha1md_pkg::vars_type                  vars_cur,
   input  logic [sha1md_pkg::WORD_W-1:0]         wt,
   input  logic [sha1md_pkg::ROUND_W-1:0]        round_idx,
   output sha1md_pkg::vars_type                  vars_nxt
);

   logic [sha1md_pkg::WORD_W-1:0] f;
   logic [sha1md_pkg::WORD_W-1:0] k;
   logic [sha1md_pkg::WORD_W-1:0] rol_a;
   logic [sha1md_pkg::WORD_W-1:0] rol_b;

   assign rol_a = {vars_cur.a[26:0], vars_cur.a[31:27]};
   assign rol_b = {vars_cur.b[1:0], vars_cur.b[31:2]};

   always_comb begin
      if (round_idx < sha1md_pkg::ROUND_G1) begin
         f = (vars_cur.b & vars_cur.c) ^ (~vars_cur.b & vars_cur.d);
         k = sha1md_pkg::K0;
      end else if (round_idx < sha1md_pkg::ROUND_G2) begin
         f = vars_cur.b ^ vars_cur.c ^ vars_cur.d;
         k = sha1md_pkg::K1;
      end else if (round_idx < sha1md_pkg::ROUND_G3) begin
         f = (vars_cur.b & vars_cur.c) ^ (vars_cur.b & vars_cur.d) ^
             (vars_cur.c & vars_cur.d);
         k = sha1md_pkg::K2;
      end else begin
         f = vars_cur.b ^ vars_cur.c ^ vars_cur.d;
         k = sha1md_pkg::K3;
      end
   end

   always_comb begin
      vars_nxt.a = rol_a + f + vars_cur.e + k + wt;
      vars_nxt.b = vars_cur.a;
      vars_nxt.c = rol_b;
      vars_nxt.d = vars_cur.c;
      vars_nxt.e = vars_cur.d;
   end

endmodule

@@ sv/sha1_message_digest.sv @@
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 digest of a message streamed as big-endian 32-bit words.
// ----------------------------------------------------------------------------
// Requests arrive on req_* : one message word per request, req_tlast on the
// final word, whose byte count (0..4, above 4 taken as 4) gives its valid
// high-order bytes. The digest leaves on rsp_* as five words, index 0 first,
// rsp_tlast on the fifth.
// A word that does not complete a block leaves req_tready high. A word that
// completes a 16-word block is followed by 80 rounds of the single shared
// round unit and a fold into the chaining value. The final word adds one
// pad/length push per remaining block slot and one or two compressions
// before the digest appears; req_tready stays low during all of this.
// The digest sits in its own output buffer, so the next message can start
// while the receiver stalls; the end of that next message waits in the fold
// cycle until the previous digest has gone.
// Reset (synchronous) loads the initial chaining value, clears length and
// word count and drops any pending digest.
// ----------------------------------------------------------------------------
module sha1_message_digest (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [31:0] data_word, [34:32] byte_count, [39:35] zero
   input  logic [sha1md_pkg::TDATA_W-1:0]     req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] digest_word, [34:32] word_index, [39:35] zero
   output logic [sha1md_pkg::TDATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast
);

   sha1md_pkg::state_type               state_ff, state_in;
   logic [sha1md_pkg::WCNT_W-1:0]       wcnt_ff, wcnt_in;
   logic [sha1md_pkg::ROUND_W-1:0]      round_ff, round_in;
   logic [sha1md_pkg::LEN_W-1:0]        bitlen_ff, bitlen_in;
   logic [sha1md_pkg::WORD_W-1:0]       hash_ff [sha1md_pkg::HASH_WORDS];
   logic [sha1md_pkg::WORD_W-1:0]       hash_in [sha1md_pkg::HASH_WORDS];
   logic [sha1md_pkg::WORD_W-1:0]       digest_ff [sha1md_pkg::HASH_WORDS];
   logic [sha1md_pkg::WORD_W-1:0]       digest_in [sha1md_pkg::HASH_WORDS];
   logic [sha1md_pkg::WORD_W-1:0]       sum [sha1md_pkg::HASH_WORDS];
   sha1md_pkg::vars_type                vars_ff, vars_in, vars_nxt;
   logic                                pad80_ff, pad80_in;
   logic                                hi_done_ff, hi_done_in;
   logic                                final_ff, final_in;
   logic                                done_ff, done_in;
   logic                                out_busy_ff, out_busy_in;
   logic [sha1md_pkg::IDX_W-1:0]        out_idx_ff, out_idx_in;

   logic                                req_fire;
   logic                                rsp_fire;
   logic                                push;
   logic [sha1md_pkg::WORD_W-1:0]       push_word;
   logic [sha1md_pkg::WORD_W-1:0]       data_word;
   logic [sha1md_pkg::CNT_W-1:0]        byte_count;
   logic [sha1md_pkg::CNT_W-1:0]        cnt_sat;
   logic [sha1md_pkg::WORD_W-1:0]       tail_word;
   logic [sha1md_pkg::WORD_W-1:0]       wt;
   sha1md_pkg::sched_ctrl_type          sched_ctrl;

   assign data_word  = req_tdata[sha1md_pkg::WORD_W-1:0];
   assign byte_count = req_tdata[sha1md_pkg::WORD_W +: sha1md_pkg::CNT_W];
   assign cnt_sat    = (byte_count > 3'd4) ? 3'd4 : byte_count;

   assign req_tready = (state_ff == sha1md_pkg::ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_tvalid = out_busy_ff;
   assign rsp_fire   = rsp_tvalid & rsp_tready;
   assign rsp_tlast  = (out_idx_ff == 3'(sha1md_pkg::HASH_WORDS - 1));
   assign rsp_tdata  = {5'b0, out_idx_ff, digest_ff[out_idx_ff]};

   // keep the valid bytes of the final word and, for fewer than four, place the pad byte after them
   always_comb begin
      case (cnt_sat)
         3'd0:    tail_word = sha1md_pkg::PAD_WORD;
         3'd1:    tail_word = {data_word[31:24], 8'h80, 16'h0000};
         3'd2:    tail_word = {data_word[31:16], 8'h80, 8'h00};
         3'd3:    tail_word = {data_word[31:8], 8'h80};
         default: tail_word = data_word;
      endcase
   end

   always_comb begin
      for (int i = 0; i < sha1md_pkg::HASH_WORDS; i++) begin
         sum[i] = hash_ff[i];
      end
      sum[0] = hash_ff[0] + vars_ff.a;
      sum[1] = hash_ff[1] + vars_ff.b;
      sum[2] = hash_ff[2] + vars_ff.c;
      sum[3] = hash_ff[3] + vars_ff.d;
      sum[4] = hash_ff[4] + vars_ff.e;
   end

   always_comb begin
      state_in    = state_ff;
      wcnt_in     = wcnt_ff;
      round_in    = round_ff;
      bitlen_in   = bitlen_ff;
      hash_in     = hash_ff;
      digest_in   = digest_ff;
      vars_in     = vars_ff;
      pad80_in    = pad80_ff;
      hi_done_in  = hi_done_ff;
      final_in    = final_ff;
      done_in     = done_ff;
      out_busy_in = out_busy_ff;
      out_idx_in  = out_idx_ff;
      push        = 1'b0;
      push_word   = '0;

      if (rsp_fire) begin
         out_idx_in = out_idx_ff + 3'd1;
         if (rsp_tlast) begin
            out_busy_in = 1'b0;
         end
      end

      case (state_ff)
         sha1md_pkg::ST_IDLE: begin
            if (req_fire) begin
               push = 1'b1;
               if (req_tlast) begin
                  push_word = tail_word;
                  bitlen_in = bitlen_ff + 64'({cnt_sat, 3'b000});
                  final_in  = 1'b1;
                  pad80_in  = (cnt_sat == 3'd4);
                  state_in  = sha1md_pkg::ST_PAD;
               end else begin
                  push_word = data_word;
                  bitlen_in = bitlen_ff + 64'd32;
               end
            end
         end
         sha1md_pkg::ST_PAD: begin
            push = 1'b1;
            if (pad80_ff) begin
               push_word = sha1md_pkg::PAD_WORD;
               pad80_in  = 1'b0;
            end else if (hi_done_ff) begin
               push_word  = bitlen_ff[sha1md_pkg::WORD_W-1:0];
               hi_done_in = 1'b0;
               done_in    = 1'b1;
            end else if (wcnt_ff == 4'd14) begin
               push_word  = bitlen_ff[sha1md_pkg::LEN_W-1:sha1md_pkg::WORD_W];
               hi_done_in = 1'b1;
            end else begin
               push_word = '0;
            end
         end
         sha1md_pkg::ST_ROUND: begin
            vars_in  = vars_nxt;
            round_in = round_ff + 7'd1;
            if (round_ff == sha1md_pkg::ROUND_LAST) begin
               state_in = sha1md_pkg::ST_UPDATE;
            end
         end
         sha1md_pkg::ST_UPDATE: begin
            if (done_ff) begin
               // hold until the previous digest has been taken
               if (!out_busy_ff) begin
                  digest_in   = sum;
                  hash_in     = sha1md_pkg::INIT_HASH;
                  bitlen_in   = '0;
                  final_in    = 1'b0;
                  done_in     = 1'b0;
                  out_busy_in = 1'b1;
                  out_idx_in  = '0;
                  state_in    = sha1md_pkg::ST_IDLE;
               end
            end else begin
               hash_in  = sum;
               state_in = final_ff ? sha1md_pkg::ST_PAD : sha1md_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sha1md_pkg::ST_IDLE;
         end
      endcase

      // a full buffer starts compression
      if (push) begin
         wcnt_in = wcnt_ff + 4'd1;
         if (wcnt_ff == 4'(sha1md_pkg::BLOCK_WORDS - 1)) begin
            state_in  = sha1md_pkg::ST_ROUND;
            round_in  = '0;
            vars_in.a = hash_ff[0];
            vars_in.b = hash_ff[1];
            vars_in.c = hash_ff[2];
            vars_in.d = hash_ff[3];
            vars_in.e = hash_ff[4];
         end
      end
   end

   assign sched_ctrl.shift  = push | (state_ff == sha1md_pkg::ST_ROUND);
   assign sched_ctrl.expand = (state_ff == sha1md_pkg::ST_ROUND);

   sha1md_sched u_sched (
      .clock     (clock),
      .ctrl      (sched_ctrl),
      .push_word (push_word),
      .wt        (wt)
   );

   sha1md_round u_round (
      .vars_cur  (vars_ff),
      .wt        (wt),
      .round_idx (round_ff),
      .vars_nxt  (vars_nxt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sha1md_pkg::ST_IDLE;
         wcnt_ff     <= '0;
         round_ff    <= '0;
         bitlen_ff   <= '0;
         hash_ff     <= sha1md_pkg::INIT_HASH;
         pad80_ff    <= 1'b0;
         hi_done_ff  <= 1'b0;
         final_ff    <= 1'b0;
         done_ff     <= 1'b0;
         out_busy_ff <= 1'b0;
         out_idx_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         wcnt_ff     <= wcnt_in;
         round_ff    <= round_in;
         bitlen_ff   <= bitlen_in;
         hash_ff     <= hash_in;
         pad80_ff    <= pad80_in;
         hi_done_ff  <= hi_done_in;
         final_ff    <= final_in;
         done_ff     <= done_in;
         out_busy_ff <= out_busy_in;
         out_idx_ff  <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      vars_ff   <= vars_in;
      digest_ff <= digest_in;
   end

`ifndef SYNTHESIS
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha1md_pkg::ST_ROUND |-> round_ff <= sha1md_pkg::ROUND_LAST)
      else $error("round counter beyond last round");

   a_buffer_empty_in_rounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha1md_pkg::ST_ROUND |-> wcnt_ff == '0)
      else $error("block buffer not empty during compression");

   a_out_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> out_idx_ff <= 3'(sha1md_pkg::HASH_WORDS - 1))
      else $error("digest word index out of range");

   a_length_only_at_end: assert property (@(posedge clock) disable iff (reset)
      hi_done_ff |-> (wcnt_ff == 4'(sha1md_pkg::BLOCK_WORDS - 1)) && final_ff)
      else $error("length word misplaced in final block");
`endif

endmodule

@@ dv/tb_sha1_message_digest.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sha1_message_digest
// Streams messages of random length and content into the digest block,
// predicts each digest in the bench and checks the five digest words in
// order, with random idling on both sides and long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb_sha1_message_digest;

   localparam int CYCLE_LIMIT     = 600000;
   localparam int RSP_HOLD_CYCLES = 600;
   localparam int DRAIN_TAIL      = 250;
   localparam int RANDOM_ITEMS    = 440;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        is_last;
   } digest_word_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [sha1md_pkg::TDATA_W-1:0] req_tdata = '0;
   logic                           req_tlast = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [sha1md_pkg::TDATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;

   // bench copy of the digest state
   logic [31:0] chain_val [5];
   logic [31:0] block_buf [16];
   logic [63:0] msg_bits;
   logic [5:0]  buf_bytes;

   digest_word_type digest_q [$];
   digest_word_type want;
   int              n_errors = 0;
   int              items_sent = 0;
   int              cycle_count = 0;
   int              rsp_stall = 0;
   bit              rsp_hold_req = 1'b0;
   bit              idle_on = 1'b1;

   sha1_message_digest uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [31:0] rotl(logic [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic void chain_start();
      for (int i = 0; i < 5; i++) chain_val[i] = sha1md_pkg::INIT_HASH[i];
      msg_bits  = '0;
      buf_bytes = '0;
   endfunction

   function automatic void compress_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, wt, tmp;
      for (int i = 0; i < 16; i++) w[i] = block_buf[i];
      a = chain_val[0]; b = chain_val[1]; c = chain_val[2];
      d = chain_val[3]; e = chain_val[4];
      for (int t = 0; t < 80; t++) begin
         if (t < 16) begin
            wt = w[t];
         end else begin
            wt = rotl(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16], 1);
            w[t % 16] = wt;
         end
         if (t < 20) begin
            f = (b & c) ^ (~b & d);
            k = sha1md_pkg::K0;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = sha1md_pkg::K1;
         end else if (t < 60) begin
            f = (b & c) ^ (b & d) ^ (c & d);
            k = sha1md_pkg::K2;
         end else begin
            f = b ^ c ^ d;
            k = sha1md_pkg::K3;
         end
         tmp = rotl(a, 5) + f + e + k + wt;
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = tmp;
      end
      chain_val[0] += a;
      chain_val[1] += b;
      chain_val[2] += c;
      chain_val[3] += d;
      chain_val[4] += e;
   endfunction

   function automatic void absorb_word(logic [31:0] v);
      block_buf[buf_bytes[5:2]] = v;
      buf_bytes += 6'd4;
      if (buf_bytes == 6'd0) compress_block();
   endfunction

   // Advance the bench state by one accepted request; queue the digest on the last word.
   function automatic void sha1_predict(logic [31:0] w, logic [2:0] cnt, logic lst);
      int              n;
      int              pos;
      logic [31:0]     keep;
      digest_word_type dw;
      if (!lst) begin
         msg_bits += 64'd32;
         absorb_word(w);
         return;
      end
      n = (cnt > 3'd4) ? 4 : int'(cnt);
      msg_bits += 64'(n * 8);
      if (n == 4) begin
         absorb_word(w);
         absorb_word(sha1md_pkg::PAD_WORD);
      end else begin
         keep = (n == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * n));
         absorb_word((w & keep) | (sha1md_pkg::PAD_WORD >> (8 * n)));
      end
      pos = int'(buf_bytes[5:2]);
      // no room for the length: close this block and start a fresh one
      if (pos == 15) begin
         block_buf[15] = '0;
         compress_block();
         pos = 0;
      end
      for (int i = pos; i < 14; i++) block_buf[i] = '0;
      block_buf[14] = msg_bits[63:32];
      block_buf[15] = msg_bits[31:0];
      compress_block();
      for (int i = 0; i < 5; i++) begin
         dw.word    = chain_val[i];
         dw.index   = 3'(i);
         dw.is_last = (i == 4);
         digest_q.push_back(dw);
      end
      chain_start();
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   function automatic logic [31:0] pick_word();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 32'h0;
      if (r == 1) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // Offer one request after an optional gap; return at the edge that takes it.
   task automatic send_word(logic [31:0] w, logic [2:0] cnt, logic lst, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, cnt, w};
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      sha1_predict(w, cnt, lst);
      items_sent++;
   endtask

   task automatic send_message(int n_words, logic [2:0] last_cnt);
      for (int i = 0; i < n_words; i++)
         send_word(pick_word(), 3'($urandom_range(0, 7)), 1'b0, pick_gap());
      send_word(pick_word(), last_cnt, 1'b1, pick_gap());
   endtask

   task automatic wait_digests_done();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (digest_q.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_edge_words();
      idle_on = 1'b1;
      send_word(32'h0, 3'd0, 1'b1, 0);                 // empty message
      send_word(32'h6162_6300, 3'd3, 1'b1, pick_gap()); // "abc"
      // all-ones word: bytes beyond the count must be dropped; counts above four act as four
      for (int c = 1; c <= 7; c++)
         send_word(32'hFFFF_FFFF, 3'(c), 1'b1, pick_gap());
      send_word(32'h0, 3'd4, 1'b1, pick_gap());
      // count on a non-last word is ignored
      send_word(32'hFFFF_FFFF, 3'd0, 1'b0, pick_gap());
      send_word(32'h1234_5678, 3'd2, 1'b1, pick_gap());
      send_word(32'h0, 3'd7, 1'b0, pick_gap());
      send_word(32'hFFFF_FFFF, 3'd0, 1'b1, pick_gap());
      wait_digests_done();
   endtask

   // Hold the receiver off while messages keep arriving, so the input stalls.
   task automatic test_output_stall();
      idle_on      = 1'b0;
      rsp_hold_req = 1'b1;
      for (int m = 0; m < 4; m++) send_message($urandom_range(3, 9), 3'($urandom_range(0, 7)));
      wait_digests_done();
   endtask

   task automatic test_random_messages();
      int len;
      int r;
      while (items_sent < RANDOM_ITEMS) begin
         idle_on = ($urandom_range(0, 4) != 0);
         r = $urandom_range(0, 99);
         if (r < 80) len = $urandom_range(0, 33);
         else len = $urandom_range(34, 70);
         send_message(len, 3'($urandom_range(0, 7)));
      end
   endtask

   // Let every digest leave before each following message.
   task automatic test_pause_for_digests();
      idle_on = 1'b1;
      for (int m = 0; m < 3; m++) begin
         send_message($urandom_range(12, 17), 3'($urandom_range(0, 7)));
         wait_digests_done();
      end
   endtask

   // ---------------------------------------------------------------- receiver
   always begin
      @(posedge clock);
      if (rsp_hold_req) begin
         rsp_hold_req = 1'b0;
         rsp_tready <= 1'b0;
         repeat (RSP_HOLD_CYCLES) @(posedge clock);
      end else if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
         if (idle_on && $urandom_range(0, 3) == 0) rsp_stall = pick_gap();
      end
   end

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_q.size() == 0) begin
            $error("digest_word: none expected, got %h", rsp_tdata[31:0]);
            n_errors++;
         end else begin
            want = digest_q.pop_front();
            if (rsp_tdata[31:0] !== want.word) begin
               $error("digest_word: expected %h, got %h", want.word, rsp_tdata[31:0]);
               n_errors++;
            end
            if (rsp_tdata[34:32] !== want.index) begin
               $error("word_index: expected %0d, got %0d", want.index, rsp_tdata[34:32]);
               n_errors++;
            end
            if (rsp_tlast !== want.is_last) begin
               $error("last_word: expected %0d, got %0d", want.is_last, rsp_tlast);
               n_errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      chain_start();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_words();
      test_output_stall();
      test_random_messages();
      wait_digests_done();
      test_output_stall();
      test_pause_for_digests();
      wait_digests_done();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (digest_q.size() != 0) begin
         $error("digest_word: %0d expected words never arrived", digest_q.size());
         n_errors++;
      end
      if (n_errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ sha1_message_digest.f @@
sv/sha1md_pkg.sv
sv/sha1md_sched.sv
sv/sha1md_round.sv
sv/sha1_message_digest.sv
dv/tb_sha1_message_digest.sv
